### hw/rtl/msp_pkg.sv
`timescale 1ns / 1ps
package msp_pkg;

  localparam int SAMPLE_TICKS_DEF = 20;

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TARGET       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P             = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I             = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_NEGATIVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT       = 3'd4;

  localparam logic [16:0] LIMIT_RESET = 17'd16384;

  localparam logic signed [21:0] ERR_MAX = 22'sh1FFFFF;
  localparam logic signed [21:0] ERR_MIN = 22'sh200000;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_CAPTURE,
    PH_LOOP
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_NUM,
    ST_DIV,
    ST_ERR,
    ST_MULP,
    ST_OUT,
    ST_MULI,
    ST_INTEG,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic speed;
    logic num;
    logic div_step;
    logic err;
    logic mul_p;
    logic pi_out;
    logic mul_i;
    logic integ;
    logic emit;
  } cmd_t;

endpackage

### hw/rtl/msp_ctrl.sv
`timescale 1ns / 1ps
module msp_ctrl #(
  parameter int SAMPLE_TICKS = msp_pkg::SAMPLE_TICKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_enable,
  output logic          in_stall,
  input  logic          out_stall,
  output logic          out_valid,
  output msp_pkg::cmd_t cmd
);

  localparam int CD_W = $clog2(SAMPLE_TICKS + 1);

  msp_pkg::state_t                   state_r, state_nxt;
  msp_pkg::phase_t                   phase_r, phase_nxt;
  logic [CD_W-1:0]                   cd_r, cd_nxt;
  logic [msp_pkg::DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic accept;
  logic emit_ok;
  logic sample_go;

  assign accept    = in_valid && (state_r == msp_pkg::ST_IDLE);
  assign emit_ok   = (state_r == msp_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
  assign sample_go = accept && in_enable && (phase_r == msp_pkg::PH_LOOP) && (cd_r == '0);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msp_pkg::ST_IDLE;
      phase_r     <= msp_pkg::PH_INIT;
      cd_r        <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cd_r        <= cd_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state, tick phase, countdown, divider count and output valid
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cd_nxt      = cd_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      msp_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_enable) begin
            phase_nxt = msp_pkg::PH_INIT;
          end else begin
            case (phase_r)
              msp_pkg::PH_CAPTURE: phase_nxt = msp_pkg::PH_LOOP;
              msp_pkg::PH_LOOP: begin
                if (cd_r != '0) begin
                  cd_nxt = cd_r - 1'b1;
                end else begin
                  cd_nxt    = CD_W'(SAMPLE_TICKS);
                  state_nxt = msp_pkg::ST_SPEED;
                end
              end
              default: phase_nxt = msp_pkg::PH_CAPTURE;
            endcase
          end
        end
      end
      msp_pkg::ST_SPEED: state_nxt = msp_pkg::ST_NUM;
      msp_pkg::ST_NUM: begin
        div_cnt_nxt = '0;
        state_nxt   = msp_pkg::ST_DIV;
      end
      msp_pkg::ST_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == msp_pkg::DIV_CNT_W'(msp_pkg::DIV_STEPS - 1)) begin
          state_nxt = msp_pkg::ST_ERR;
        end
      end
      msp_pkg::ST_ERR:   state_nxt = msp_pkg::ST_MULP;
      msp_pkg::ST_MULP:  state_nxt = msp_pkg::ST_OUT;
      msp_pkg::ST_OUT:   state_nxt = msp_pkg::ST_MULI;
      msp_pkg::ST_MULI:  state_nxt = msp_pkg::ST_INTEG;
      msp_pkg::ST_INTEG: state_nxt = msp_pkg::ST_EMIT;
      msp_pkg::ST_EMIT: begin
        if (emit_ok) begin
          state_nxt = msp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msp_pkg::ST_IDLE;
    endcase

    if (emit_ok) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // datapath commands and input stall
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      msp_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = accept && in_enable && (phase_r == msp_pkg::PH_CAPTURE);
        cmd.load    = sample_go;
      end
      msp_pkg::ST_SPEED: cmd.speed    = 1'b1;
      msp_pkg::ST_NUM:   cmd.num      = 1'b1;
      msp_pkg::ST_DIV:   cmd.div_step = 1'b1;
      msp_pkg::ST_ERR:   cmd.err      = 1'b1;
      msp_pkg::ST_MULP:  cmd.mul_p    = 1'b1;
      msp_pkg::ST_OUT:   cmd.pi_out   = 1'b1;
      msp_pkg::ST_MULI:  cmd.mul_i    = 1'b1;
      msp_pkg::ST_INTEG: cmd.integ    = 1'b1;
      msp_pkg::ST_EMIT:  cmd.emit     = emit_ok;
      default:           cmd          = '0;
    endcase
  end

endmodule

### hw/rtl/msp_dpath.sv
`timescale 1ns / 1ps
module msp_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [15:0]                     in_encoder_count,
  input  msp_pkg::cmd_t                   cmd,
  output logic signed [21:0]              out_speed_rpm,
  output logic signed [21:0]              out_norm_error,
  output logic signed [17:0]              out_current_command
);

  function automatic logic signed [17:0] clamp_lim(logic signed [31:0] x, logic [16:0] lim);
    logic signed [31:0] hi;
    hi = $signed({15'd0, lim});
    if (x > hi) begin
      clamp_lim = hi[17:0];
    end else if (x < -hi) begin
      clamp_lim = 18'(-hi);
    end else begin
      clamp_lim = x[17:0];
    end
  endfunction

  // configuration
  logic signed [15:0] target_r;
  logic [23:0]        gain_p_r;
  logic [23:0]        gain_i_r;
  logic               dir_r;
  logic [16:0]        limit_r;

  // loop state
  logic [15:0]        start_r;
  logic signed [17:0] integ_r;

  // sample pipeline
  logic signed [15:0] delta_r;
  logic signed [21:0] speed_r;
  logic               neg_r;
  logic               tzero_r;
  logic [15:0]        mag_r;
  logic [15:0]        rem_r;
  logic [31:0]        quo_r;
  logic signed [21:0] err_r;
  logic signed [46:0] prod_r;
  logic signed [17:0] o_r;

  logic signed [21:0] spd_out_r;
  logic signed [21:0] err_out_r;
  logic signed [17:0] cmd_out_r;

  logic signed [25:0] sp_full;
  logic signed [32:0] num_a;
  logic signed [32:0] num_b;
  logic signed [32:0] num;
  logic [32:0]        num_abs;
  logic [15:0]        tgt_abs;
  logic [16:0]        rem_sh;
  logic               fits;
  logic [16:0]        rem_sub;
  logic signed [21:0] err_sat;
  logic signed [21:0] mul_a;
  logic [23:0]        mul_b;
  logic signed [46:0] prod_c;
  logic signed [31:0] pi_sum;
  logic signed [31:0] int_sum;
  logic signed [17:0] cmd_val;

  // rounded Q.8 rpm: (delta*375 + 4) >> 3
  assign sp_full = {{10{delta_r[15]}}, delta_r} * 26'sd375 + 26'sd4;

  assign num_a   = {{3{speed_r[21]}}, speed_r, 8'd0};
  assign num_b   = {target_r[15], target_r, 16'd0};
  assign num     = num_a - num_b;
  assign num_abs = num[32] ? 33'(-num) : 33'(num);
  assign tgt_abs = target_r[15] ? 16'(-target_r) : 16'(target_r);

  assign rem_sh  = {rem_r, quo_r[31]};
  assign fits    = rem_sh >= {1'b0, mag_r};
  assign rem_sub = rem_sh - {1'b0, mag_r};

  always_comb begin
    if (tzero_r) begin
      err_sat = '0;
    end else if (neg_r) begin
      err_sat = (quo_r > 32'd2097152) ? msp_pkg::ERR_MIN : 22'(-$signed(quo_r[21:0]));
    end else begin
      err_sat = (quo_r > 32'd2097151) ? msp_pkg::ERR_MAX : $signed(quo_r[21:0]);
    end
  end

  // one shared multiplier for both gains
  assign mul_a  = cmd.mul_i ? {{4{o_r[17]}}, o_r} : err_r;
  assign mul_b  = cmd.mul_i ? gain_i_r : gain_p_r;
  assign prod_c = 47'(mul_a) * 47'($signed({1'b0, mul_b}));

  assign pi_sum  = {prod_r[46], prod_r[46:16]} + 32'(integ_r);
  assign int_sum = 32'(integ_r) + {prod_r[46], prod_r[46:16]};
  assign cmd_val = dir_r ? 18'(-o_r) : o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      dir_r    <= 1'b0;
      limit_r  <= msp_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        msp_pkg::CFG_SPEED_TARGET:       target_r <= $signed(cfg_wdata[15:0]);
        msp_pkg::CFG_GAIN_P:             gain_p_r <= cfg_wdata;
        msp_pkg::CFG_GAIN_I:             gain_i_r <= cfg_wdata;
        msp_pkg::CFG_DIRECTION_NEGATIVE: dir_r    <= cfg_wdata[0];
        msp_pkg::CFG_OUTPUT_LIMIT:       limit_r  <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      integ_r <= '0;
    end else begin
      if (cmd.capture) begin
        start_r <= in_encoder_count;
        integ_r <= '0;
      end else if (cmd.load) begin
        start_r <= in_encoder_count;
      end else if (cmd.integ) begin
        integ_r <= clamp_lim(int_sum, limit_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      delta_r <= $signed(in_encoder_count - start_r);
    end
    if (cmd.speed) begin
      speed_r <= sp_full[24:3];
    end
    if (cmd.num) begin
      neg_r   <= num[32];
      tzero_r <= (target_r == '0);
      mag_r   <= tgt_abs;
      rem_r   <= '0;
      quo_r   <= num_abs[31:0];
    end
    if (cmd.div_step) begin
      rem_r <= fits ? rem_sub[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[30:0], fits};
    end
    if (cmd.err) begin
      err_r <= err_sat;
    end
    if (cmd.mul_p || cmd.mul_i) begin
      prod_r <= prod_c;
    end
    if (cmd.pi_out) begin
      o_r <= clamp_lim(pi_sum, limit_r);
    end
    if (cmd.emit) begin
      spd_out_r <= speed_r;
      err_out_r <= err_r;
      cmd_out_r <= cmd_val;
    end
  end

  assign out_speed_rpm       = spd_out_r;
  assign out_norm_error      = err_out_r;
  assign out_current_command = cmd_out_r;

endmodule

### hw/rtl/motor_speed_pi_loop_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_enable, in_encoder_count
// out_      output     out_valid / out_stall out_speed_rpm, out_norm_error,
//                                            out_current_command
// cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// a tick that takes no sample leaves the block idle; a sample tick runs
// speed, numerator, the restoring divider (one quotient bit a cycle), error,
// P multiply, output, I multiply (shared multiplier), integrate and emit.
// rst_n is synchronous; it clears the tick phase, countdown, integrator and
// start count and loads the register reset values.
// results sit in an output register, so out_stall holds only that register;
// new ticks are taken while a result waits, and a sample stalls in its last
// state until the output register is free.
module motor_speed_pi_loop_top #(
  parameter int SAMPLE_TICKS = msp_pkg::SAMPLE_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_enable,
  input  logic [15:0]                     in_encoder_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [21:0]              out_speed_rpm,
  output logic signed [21:0]              out_norm_error,
  output logic signed [17:0]              out_current_command
);

  msp_pkg::cmd_t cmd;

  msp_ctrl #(
    .SAMPLE_TICKS(SAMPLE_TICKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_enable (in_enable),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  msp_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_encoder_count    (in_encoder_count),
    .cmd                 (cmd),
    .out_speed_rpm       (out_speed_rpm),
    .out_norm_error      (out_norm_error),
    .out_current_command (out_current_command)
  );

endmodule

### hw/rtl/msp_chk.sv
`timescale 1ns / 1ps
module msp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [21:0]              out_speed_rpm,
  input logic signed [21:0]              out_norm_error,
  input logic signed [17:0]              out_current_command
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_command)
      && $stable(out_norm_error) && $stable(out_speed_rpm))
    else $error("result changed while stalled");

  // a result only appears at the end of a sample, when input is held off
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a sample in progress");

  // command magnitude never exceeds the widest clamp
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_command != 18'sh20000)
    else $error("current command out of range");

  // ready for a transaction right after reset
  a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind motor_speed_pi_loop_top msp_chk u_chk (.*);
